// File: rtl/core/quintic_trajectory_evaluator_top_defines.svh
// Assertion macros for the quintic trajectory evaluator.
// Included by the top level; expects signals clock and reset in scope.
`ifndef QUINTIC_TRAJECTORY_EVALUATOR_TOP_DEFINES_SVH
`define QUINTIC_TRAJECTORY_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication
`define QTE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qte: same-cycle check failed");

// next-cycle implication
`define QTE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qte: next-cycle check failed");

`endif

// File: rtl/core/qte_pkg.sv
// Shared types, constants and saturating arithmetic for the quintic evaluator.
// No dependencies.
package qte_pkg;

   localparam int DIV_STEPS = 32;

   typedef logic signed [63:0] s64_type;
   typedef logic [71:0]        mag72_type;

   localparam s64_type S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam s64_type S64_MIN = 64'sh8000_0000_0000_0000;

   localparam logic [4:0] K2  = 5'd2;
   localparam logic [4:0] K3  = 5'd3;
   localparam logic [4:0] K4  = 5'd4;
   localparam logic [4:0] K5  = 5'd5;
   localparam logic [4:0] K6  = 5'd6;
   localparam logic [4:0] K7  = 5'd7;
   localparam logic [4:0] K8  = 5'd8;
   localparam logic [4:0] K10 = 5'd10;
   localparam logic [4:0] K12 = 5'd12;
   localparam logic [4:0] K15 = 5'd15;
   localparam logic [4:0] K20 = 5'd20;

   typedef enum logic [2:0] {
      REG_START_TIME,
      REG_END_TIME,
      REG_START_POSITION,
      REG_START_VELOCITY,
      REG_START_ACCEL,
      REG_END_POSITION,
      REG_END_VELOCITY,
      REG_END_ACCEL
   } reg_index_type;

   typedef enum logic [1:0] {
      PHASE_START  = 2'd0,
      PHASE_INSIDE = 2'd1,
      PHASE_END    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [31:0] start_time;
      logic [31:0] end_time;
      logic [31:0] start_position;
      logic [31:0] start_velocity;
      logic [31:0] start_accel;
      logic [31:0] end_position;
      logic [31:0] end_velocity;
      logic [31:0] end_accel;
   } cfg_type;

   // one restoring-division word: partial remainder, dividend/quotient shift word, tags
   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] word;
      logic        neg;
      logic        ovf;
   } div_type;

   typedef struct packed {
      logic [31:0] t;
      logic [63:0] tt;
      s64_type     p0;
      s64_type     vt0;
      s64_type     ah0;
      s64_type     c3;
      s64_type     c4;
      s64_type     c5;
      s64_type     c3x3;
      s64_type     c4x4;
      s64_type     c5x5;
      s64_type     ah0x2;
      s64_type     c3x6;
      s64_type     c4x12;
      s64_type     c5x20;
   } coef_type;

   function automatic s64_type sat_pack(input logic neg, input mag72_type mag);
      s64_type res;
      if (neg) begin
         if (mag >= 72'h8000_0000_0000_0000) res = S64_MIN;
         else res = s64_type'(64'd0 - mag[63:0]);
      end else begin
         if (mag > 72'h7FFF_FFFF_FFFF_FFFF) res = S64_MAX;
         else res = s64_type'(mag[63:0]);
      end
      return res;
   endfunction

   function automatic s64_type sat_add(input s64_type a, input s64_type b);
      logic [64:0] sum;
      s64_type     res;
      sum = {a[63], a} + {b[63], b};
      if (sum[64] != sum[63]) res = sum[64] ? S64_MIN : S64_MAX;
      else res = s64_type'(sum[63:0]);
      return res;
   endfunction

   function automatic s64_type sat_sub(input s64_type a, input s64_type b);
      logic [64:0] dif;
      s64_type     res;
      dif = {a[63], a} - {b[63], b};
      if (dif[64] != dif[63]) res = dif[64] ? S64_MIN : S64_MAX;
      else res = s64_type'(dif[63:0]);
      return res;
   endfunction

   function automatic logic [63:0] mag64(input s64_type a);
      logic [63:0] u;
      u = a;
      return a[63] ? (64'd0 - u) : u;
   endfunction

   function automatic s64_type mulk(input s64_type x, input logic [4:0] k);
      mag72_type p;
      p = mag72_type'(mag64(x)) * mag72_type'(k);
      return sat_pack(x[63], p);
   endfunction

   function automatic logic [31:0] sat32(input s64_type x);
      logic [31:0] res;
      if (x > 64'sd2147483647) res = 32'h7FFF_FFFF;
      else if (x < -64'sd2147483648) res = 32'h8000_0000;
      else res = x[31:0];
      return res;
   endfunction

   // signed, saturated result of a finished division word
   function automatic logic [31:0] quot_sat(input div_type d);
      return sat32(sat_pack(d.neg, {39'd0, d.ovf, d.word}));
   endfunction

   function automatic s64_type sext32(input logic [31:0] x);
      return s64_type'({{32{x[31]}}, x});
   endfunction

endpackage

// File: rtl/core/quintic_trajectory_evaluator_top.sv
// Quintic trajectory evaluator: query time in, position, velocity and acceleration out.
// Depends on qte_pkg, qte_coef, qte_div_row, qte_mac and the assertion macro header.
//
// Takes one query word per cycle unless the result side stalls, and returns one result word
// per query, in order. The path runs through two rows of 32 restoring-division cells in
// series (normalised time, then velocity and acceleration scaling side by side), four Horner
// steps of the velocity lane, and one register each at the input, the divider set-up and
// the output. Coefficients come from a free-running pipeline fed by the registers; it
// settles after a write well inside the time a query takes to reach it, so a query may
// follow a register write from the next cycle. A stall on the result side holds the whole
// pipeline; req_ready is low only while a result waits untaken.
`include "quintic_trajectory_evaluator_top_defines.svh"

module quintic_trajectory_evaluator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_query_time,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity,
   output logic signed [31:0] rsp_acceleration,
   output logic [1:0]         rsp_segment_phase,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import qte_pkg::*;

   localparam int MAC_LAT   = 2;
   localparam int POS_STEPS = 5;
   localparam int VEL_STEPS = 4;
   localparam int ACC_STEPS = 3;
   localparam int POS_END   = DIV_STEPS + MAC_LAT * POS_STEPS;
   localparam int VEL_END   = DIV_STEPS + MAC_LAT * VEL_STEPS;
   localparam int ACC_PAD   = MAC_LAT * (VEL_STEPS - ACC_STEPS);
   localparam int PREP      = VEL_END + 1;
   localparam int LAST      = PREP + DIV_STEPS;
   localparam int POS_DLY   = LAST - POS_END;

   cfg_type     cfg_ff;
   coef_type    coef;
   logic        adv;
   logic        accept;
   logic [LAST:0] vld_ff;
   phase_type   phase_in;
   phase_type   phase_ff [0:LAST];
   logic [31:0] tau_ff;

   div_type     srow_in, srow_out;
   logic [31:0] s_word;

   s64_type     pos_acc  [0:POS_STEPS];
   logic [31:0] pos_s    [0:POS_STEPS];
   s64_type     pos_term [0:POS_STEPS-1];
   s64_type     vel_acc  [0:VEL_STEPS];
   logic [31:0] vel_s    [0:VEL_STEPS];
   s64_type     vel_term [0:VEL_STEPS-1];
   s64_type     acc_acc  [0:ACC_STEPS];
   logic [31:0] acc_s    [0:ACC_STEPS];
   s64_type     acc_term [0:ACC_STEPS-1];
   s64_type     accd_ff  [0:ACC_PAD-1];

   logic [63:0] vmag, amag;
   div_type     vprep_in, aprep_in, vprep_ff, aprep_ff;
   div_type     vrow_out, arow_out;
   logic [31:0] posd_ff [0:POS_DLY-1];

   logic        rsp_valid_ff;
   logic [31:0] pos_in, vel_in, acc_in;
   logic [31:0] rsp_pos_ff, rsp_vel_ff, rsp_acc_ff;
   logic [1:0]  rsp_phase_ff;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_START_TIME:     cfg_ff.start_time     <= csr_wdata;
            REG_END_TIME:       cfg_ff.end_time       <= csr_wdata;
            REG_START_POSITION: cfg_ff.start_position <= csr_wdata;
            REG_START_VELOCITY: cfg_ff.start_velocity <= csr_wdata;
            REG_START_ACCEL:    cfg_ff.start_accel    <= csr_wdata;
            REG_END_POSITION:   cfg_ff.end_position   <= csr_wdata;
            REG_END_VELOCITY:   cfg_ff.end_velocity   <= csr_wdata;
            REG_END_ACCEL:      cfg_ff.end_accel      <= csr_wdata;
            default: ;
         endcase
      end
   end

   qte_coef u_coef (
      .clock (clock),
      .cfg   (cfg_ff),
      .coef  (coef)
   );

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   // end clamp is tested first
   always_comb begin
      if (req_query_time >= cfg_ff.end_time) phase_in = PHASE_END;
      else if (req_query_time <= cfg_ff.start_time) phase_in = PHASE_START;
      else phase_in = PHASE_INSIDE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         phase_ff[0] <= phase_in;
         tau_ff      <= req_query_time - cfg_ff.start_time;
         for (int i = 1; i <= LAST; i++) phase_ff[i] <= phase_ff[i-1];
      end
   end

   // s = tau * 2^32 / T
   assign srow_in = '{rem: {32'd0, tau_ff}, word: 32'd0, neg: 1'b0, ovf: 1'b0};

   qte_div_row u_srow (
      .clock   (clock),
      .en      (adv),
      .divisor ({32'd0, coef.t}),
      .d_in    (srow_in),
      .d_out   (srow_out)
   );

   assign s_word = srow_out.word;

   // Horner lanes
   assign pos_acc[0]  = coef.c5;
   assign pos_s[0]    = s_word;
   assign pos_term[0] = coef.c4;
   assign pos_term[1] = coef.c3;
   assign pos_term[2] = coef.ah0;
   assign pos_term[3] = coef.vt0;
   assign pos_term[4] = coef.p0;

   assign vel_acc[0]  = coef.c5x5;
   assign vel_s[0]    = s_word;
   assign vel_term[0] = coef.c4x4;
   assign vel_term[1] = coef.c3x3;
   assign vel_term[2] = coef.ah0x2;
   assign vel_term[3] = coef.vt0;

   assign acc_acc[0]  = coef.c5x20;
   assign acc_s[0]    = s_word;
   assign acc_term[0] = coef.c4x12;
   assign acc_term[1] = coef.c3x6;
   assign acc_term[2] = coef.ah0x2;

   for (genvar i = 0; i < POS_STEPS; i++) begin : g_pos
      qte_mac u_mac (
         .clock (clock), .en (adv),
         .acc_in (pos_acc[i]), .s_in (pos_s[i]), .term (pos_term[i]),
         .acc_out (pos_acc[i+1]), .s_out (pos_s[i+1])
      );
   end

   for (genvar i = 0; i < VEL_STEPS; i++) begin : g_vel
      qte_mac u_mac (
         .clock (clock), .en (adv),
         .acc_in (vel_acc[i]), .s_in (vel_s[i]), .term (vel_term[i]),
         .acc_out (vel_acc[i+1]), .s_out (vel_s[i+1])
      );
   end

   for (genvar i = 0; i < ACC_STEPS; i++) begin : g_acc
      qte_mac u_mac (
         .clock (clock), .en (adv),
         .acc_in (acc_acc[i]), .s_in (acc_s[i]), .term (acc_term[i]),
         .acc_out (acc_acc[i+1]), .s_out (acc_s[i+1])
      );
   end

   // align the shorter acceleration lane with velocity
   always_ff @(posedge clock) begin
      if (adv) begin
         accd_ff[0] <= acc_acc[ACC_STEPS];
         for (int i = 1; i < ACC_PAD; i++) accd_ff[i] <= accd_ff[i-1];
      end
   end

   // divider set-up: quotient fits 32 bits unless the upper dividend reaches the divisor
   always_comb begin
      vmag = mag64(vel_acc[VEL_STEPS]);
      amag = mag64(accd_ff[ACC_PAD-1]);
      vprep_in.rem  = {16'd0, vmag[63:16]};
      vprep_in.word = {vmag[15:0], 16'd0};
      vprep_in.neg  = vel_acc[VEL_STEPS][63];
      vprep_in.ovf  = ({16'd0, vmag[63:16]} >= {32'd0, coef.t});
      aprep_in.rem  = amag;
      aprep_in.word = 32'd0;
      aprep_in.neg  = accd_ff[ACC_PAD-1][63];
      aprep_in.ovf  = (amag >= coef.tt);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vprep_ff <= vprep_in;
         aprep_ff <= aprep_in;
      end
   end

   qte_div_row u_vrow (
      .clock   (clock),
      .en      (adv),
      .divisor ({32'd0, coef.t}),
      .d_in    (vprep_ff),
      .d_out   (vrow_out)
   );

   qte_div_row u_arow (
      .clock   (clock),
      .en      (adv),
      .divisor (coef.tt),
      .d_in    (aprep_ff),
      .d_out   (arow_out)
   );

   // hold position until the divider rows finish
   always_ff @(posedge clock) begin
      if (adv) begin
         posd_ff[0] <= sat32(pos_acc[POS_STEPS]);
         for (int i = 1; i < POS_DLY; i++) posd_ff[i] <= posd_ff[i-1];
      end
   end

   always_comb begin
      case (phase_ff[LAST])
         PHASE_END: begin
            pos_in = cfg_ff.end_position;
            vel_in = cfg_ff.end_velocity;
            acc_in = cfg_ff.end_accel;
         end
         PHASE_INSIDE: begin
            pos_in = posd_ff[POS_DLY-1];
            vel_in = quot_sat(vrow_out);
            acc_in = quot_sat(arow_out);
         end
         default: begin
            pos_in = cfg_ff.start_position;
            vel_in = cfg_ff.start_velocity;
            acc_in = cfg_ff.start_accel;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pos_ff   <= pos_in;
         rsp_vel_ff   <= vel_in;
         rsp_acc_ff   <= acc_in;
         rsp_phase_ff <= phase_ff[LAST];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position      = $signed(rsp_pos_ff);
   assign rsp_velocity      = $signed(rsp_vel_ff);
   assign rsp_acceleration  = $signed(rsp_acc_ff);
   assign rsp_segment_phase = rsp_phase_ff;

   `QTE_ASSERT_IMP(a_ready_when_empty, !rsp_valid_ff, req_ready)
   `QTE_ASSERT_IMP(a_end_clamp, rsp_valid && rsp_segment_phase == PHASE_END, rsp_position == $signed(cfg_ff.end_position))
   `QTE_ASSERT_NXT(a_stall_holds_pipe, !reset && rsp_valid_ff && !rsp_ready, $stable(vld_ff))

endmodule

// File: rtl/core/qte_div_cell.sv
// One restoring-division step: shift in a dividend bit, trial subtract, shift in a quotient bit.
// Depends on qte_pkg.
module qte_div_cell (
   input  logic             clock,
   input  logic             en,
   input  logic [63:0]      divisor,
   input  qte_pkg::div_type d_in,
   output qte_pkg::div_type d_out
);
   import qte_pkg::*;

   logic [64:0] trial;
   logic [64:0] diff;
   logic        ge;
   div_type     d_in_n;
   div_type     d_ff;

   always_comb begin
      trial         = {d_in.rem, d_in.word[31]};
      diff          = trial - {1'b0, divisor};
      ge            = (trial >= {1'b0, divisor});
      d_in_n.rem    = ge ? diff[63:0] : trial[63:0];
      d_in_n.word   = {d_in.word[30:0], ge};
      d_in_n.neg    = d_in.neg;
      d_in_n.ovf    = d_in.ovf;
   end

   always_ff @(posedge clock) begin
      if (en) d_ff <= d_in_n;
   end

   assign d_out = d_ff;

endmodule

// File: rtl/core/qte_div_row.sv
// A row of division cells, one quotient bit per cell, handing the word along each cycle that en is high.
// Depends on qte_pkg and qte_div_cell.
module qte_div_row (
   input  logic             clock,
   input  logic             en,
   input  logic [63:0]      divisor,
   input  qte_pkg::div_type d_in,
   output qte_pkg::div_type d_out
);
   import qte_pkg::*;

   div_type link [0:DIV_STEPS];

   assign link[0] = d_in;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      qte_div_cell u_cell (
         .clock   (clock),
         .en      (en),
         .divisor (divisor),
         .d_in    (link[i]),
         .d_out   (link[i+1])
      );
   end

   assign d_out = link[DIV_STEPS];

endmodule

// File: rtl/core/qte_mac.sv
// Pipelined Horner step: acc*s (Q0.32, toward zero, saturated) plus a term.
// Depends on qte_pkg.
module qte_mac (
   input  logic             clock,
   input  logic             en,
   input  qte_pkg::s64_type acc_in,
   input  logic [31:0]      s_in,
   input  qte_pkg::s64_type term,
   output qte_pkg::s64_type acc_out,
   output logic [31:0]      s_out
);
   import qte_pkg::*;

   logic [63:0] mag;
   logic [63:0] ph_in, pl_in;
   logic [63:0] ph_ff, pl_ff;
   logic        neg_ff;
   logic [31:0] sa_ff, sb_ff;
   mag72_type   sum;
   s64_type     acc_in_n;
   s64_type     acc_ff;

   // split the magnitude so each product stays 32 by 32
   assign mag   = mag64(acc_in);
   assign ph_in = mag[63:32] * s_in;
   assign pl_in = mag[31:0] * s_in;

   always_ff @(posedge clock) begin
      if (en) begin
         ph_ff  <= ph_in;
         pl_ff  <= pl_in;
         neg_ff <= acc_in[63];
         sa_ff  <= s_in;
      end
   end

   assign sum      = mag72_type'(ph_ff) + mag72_type'(pl_ff[63:32]);
   assign acc_in_n = sat_add(sat_pack(neg_ff, sum), term);

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in_n;
         sb_ff  <= sa_ff;
      end
   end

   assign acc_out = acc_ff;
   assign s_out   = sb_ff;

endmodule

// File: rtl/core/qte_coef.sv
// Free-running pipeline that turns the register set into polynomial coefficients.
// Depends on qte_pkg.
module qte_coef (
   input  logic              clock,
   input  qte_pkg::cfg_type  cfg,
   output qte_pkg::coef_type coef
);
   import qte_pkg::*;

   logic [31:0] mv0, mv1, ma0, ma1;
   logic [31:0] t_ff;
   s64_type     h_ff;
   logic [63:0] pv0_ff, pv1_ff, tt_ff;
   s64_type     vt0_ff, vt1_ff;
   logic [63:0] pa0h_ff, pa0l_ff, pa1h_ff, pa1l_ff;
   logic [95:0] w0, w1;
   s64_type     ah0_ff, ah1_ff;
   s64_type     h10_ff, h15_ff, h6_ff;
   s64_type     vt0x6_ff, vt0x8_ff, vt0x3_ff;
   s64_type     vt1x4_ff, vt1x7_ff, vt1x3_ff;
   s64_type     ah0x3_ff, ah1x2_ff;
   s64_type     c3a_ff, c4a_ff, c5a_ff;
   s64_type     c3b_ff, c4b_ff, c5b_ff;
   s64_type     c3c_ff, c4c_ff, c5c_ff;
   s64_type     c3_ff, c4d_ff, c5_ff, c4_ff;
   s64_type     c3x3_ff, c4x4_ff, c5x5_ff, ah0x2_ff, c3x6_ff, c4x12_ff, c5x20_ff;

   assign mv0 = cfg.start_velocity[31] ? 32'd0 - cfg.start_velocity : cfg.start_velocity;
   assign mv1 = cfg.end_velocity[31]   ? 32'd0 - cfg.end_velocity   : cfg.end_velocity;
   assign ma0 = cfg.start_accel[31]    ? 32'd0 - cfg.start_accel    : cfg.start_accel;
   assign ma1 = cfg.end_accel[31]      ? 32'd0 - cfg.end_accel      : cfg.end_accel;

   assign w0 = {pa0h_ff, 32'd0} + {32'd0, pa0l_ff};
   assign w1 = {pa1h_ff, 32'd0} + {32'd0, pa1l_ff};

   always_ff @(posedge clock) begin
      // duration and position step
      t_ff    <= cfg.end_time - cfg.start_time;
      h_ff    <= sext32(cfg.end_position) - sext32(cfg.start_position);
      // velocity and duration products
      pv0_ff  <= mv0 * t_ff;
      pv1_ff  <= mv1 * t_ff;
      tt_ff   <= t_ff * t_ff;
      // V = v*T, and a*T^2 in two halves
      vt0_ff  <= cfg.start_velocity[31] ? s64_type'(64'd0 - (pv0_ff >> 16))
                                        : s64_type'(pv0_ff >> 16);
      vt1_ff  <= cfg.end_velocity[31]   ? s64_type'(64'd0 - (pv1_ff >> 16))
                                        : s64_type'(pv1_ff >> 16);
      pa0h_ff <= ma0 * tt_ff[63:32];
      pa0l_ff <= ma0 * tt_ff[31:0];
      pa1h_ff <= ma1 * tt_ff[63:32];
      pa1l_ff <= ma1 * tt_ff[31:0];
      // A = a*T^2/2
      ah0_ff  <= cfg.start_accel[31] ? s64_type'(64'd0 - {2'b0, w0[94:33]})
                                     : s64_type'({2'b0, w0[94:33]});
      ah1_ff  <= cfg.end_accel[31]   ? s64_type'(64'd0 - {2'b0, w1[94:33]})
                                     : s64_type'({2'b0, w1[94:33]});
      // scaled terms
      h10_ff   <= mulk(h_ff, K10);
      h15_ff   <= mulk(h_ff, K15);
      h6_ff    <= mulk(h_ff, K6);
      vt0x6_ff <= mulk(vt0_ff, K6);
      vt0x8_ff <= mulk(vt0_ff, K8);
      vt0x3_ff <= mulk(vt0_ff, K3);
      vt1x4_ff <= mulk(vt1_ff, K4);
      vt1x7_ff <= mulk(vt1_ff, K7);
      vt1x3_ff <= mulk(vt1_ff, K3);
      ah0x3_ff <= mulk(ah0_ff, K3);
      ah1x2_ff <= mulk(ah1_ff, K2);
      // saturating sums, left to right, one add a cycle
      c3a_ff <= sat_sub(h10_ff, vt0x6_ff);
      c4a_ff <= sat_sub(64'sd0, h15_ff);
      c5a_ff <= sat_sub(h6_ff, vt0x3_ff);
      c3b_ff <= sat_sub(c3a_ff, vt1x4_ff);
      c4b_ff <= sat_add(c4a_ff, vt0x8_ff);
      c5b_ff <= sat_sub(c5a_ff, vt1x3_ff);
      c3c_ff <= sat_sub(c3b_ff, ah0x3_ff);
      c4c_ff <= sat_add(c4b_ff, vt1x7_ff);
      c5c_ff <= sat_sub(c5b_ff, ah0_ff);
      c3_ff  <= sat_add(c3c_ff, ah1_ff);
      c4d_ff <= sat_add(c4c_ff, ah0x3_ff);
      c5_ff  <= sat_add(c5c_ff, ah1_ff);
      c4_ff  <= sat_sub(c4d_ff, ah1x2_ff);
      // derivative coefficients
      c3x3_ff  <= mulk(c3_ff, K3);
      c4x4_ff  <= mulk(c4_ff, K4);
      c5x5_ff  <= mulk(c5_ff, K5);
      ah0x2_ff <= mulk(ah0_ff, K2);
      c3x6_ff  <= mulk(c3_ff, K6);
      c4x12_ff <= mulk(c4_ff, K12);
      c5x20_ff <= mulk(c5_ff, K20);
   end

   always_comb begin
      coef.t     = t_ff;
      coef.tt    = tt_ff;
      coef.p0    = sext32(cfg.start_position);
      coef.vt0   = vt0_ff;
      coef.ah0   = ah0_ff;
      coef.c3    = c3_ff;
      coef.c4    = c4_ff;
      coef.c5    = c5_ff;
      coef.c3x3  = c3x3_ff;
      coef.c4x4  = c4x4_ff;
      coef.c5x5  = c5x5_ff;
      coef.ah0x2 = ah0x2_ff;
      coef.c3x6  = c3x6_ff;
      coef.c4x12 = c4x12_ff;
      coef.c5x20 = c5x20_ff;
   end

endmodule
